>>> rtl/butterworth_mask_coefficient_defines.svh
// Assertion macros for the Butterworth mask coefficient block.
`ifndef BUTTERWORTH_MASK_COEFFICIENT_DEFINES_SVH
`define BUTTERWORTH_MASK_COEFFICIENT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BMC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define BMC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define BMC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BMC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/bmc_pkg.sv
// Shared constants and types of the Butterworth mask coefficient block.
package bmc_pkg;

  localparam int MAX_DIM        = 1024;
  localparam int GAIN_FRAC_BITS = 15;
  localparam int MAX_ORDER      = 10;
  localparam int Q_FRAC         = 16;

  // field widths
  localparam int IDX_W   = 10;
  localparam int RAD_W   = 10;
  localparam int ORD_W   = 4;
  localparam int KIND_W  = 2;
  localparam int DIM_W   = 11;
  localparam int GAIN_W  = GAIN_FRAC_BITS + 2;
  localparam int H_W     = GAIN_FRAC_BITS + 1;

  // config port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 8'd4;

  // filter kinds
  localparam logic [KIND_W-1:0] KIND_LOW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HIGH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIFF = 2'd2;

  // arithmetic datapath
  localparam int Q_W    = 32;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int D2_W   = 2 * IDX_W + 1;
  localparam int DENR_W = 2 * RAD_W;
  localparam int DEN_W  = Q_W + 1;
  localparam int DVD_W  = 32;
  localparam int STEP_W = 6;
  localparam int HNUM_W = GAIN_FRAC_BITS + Q_FRAC + 3;

  localparam logic [STEP_W-1:0] Q_STEPS = STEP_W'(Q_W);
  localparam logic [STEP_W-1:0] H_STEPS = STEP_W'(H_W);

  typedef struct packed {
    logic              start;
    logic [DEN_W-1:0]  rem;
    logic [DVD_W-1:0]  dvd;
    logic [DEN_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

>>> rtl/bmc_if.sv
// Channel interfaces: bin coordinates in, coefficient out, config writes.
interface bmc_in_if import bmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] row_index;
  logic [IDX_W-1:0] col_index;
  modport source (output valid, output row_index, output col_index, input ready);
  modport sink   (input valid, input row_index, input col_index, output ready);
endinterface

interface bmc_out_if import bmc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GAIN_W-1:0] mask_gain;
  modport source (output valid, output mask_gain, input ready);
  modport sink   (input valid, input mask_gain, output ready);
endinterface

interface bmc_cfg_if import bmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/bmc_mul.sv
// Shared 32x32 multiplier with registered product.
module bmc_mul import bmc_pkg::*; (
  input  logic              clk_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/bmc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module bmc_div import bmc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic [DVD_W-1:0] quot_o,
  output logic             done_o
);

  logic [DEN_W-1:0]  rem_q, den_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DEN_W:0]    shifted, diff;
  logic              take;

  // remainder shifted by one dividend bit, then trial subtract
  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign take    = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == STEP_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEP_W'(1);
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.rem;
      dvd_q <= req_i.dvd;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], take};
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

>>> rtl/butterworth_mask_coefficient.sv
// Top level: Butterworth frequency-plane mask coefficient, one bin per item.
//
//   port   dir  modport  payload                   item accepted when
//   cfg_i  in   sink     index, data               cfg_i.valid && cfg_i.ready
//   in_i   in   sink     row_index, col_index      in_i.valid && in_i.ready
//   out_o  out  source   mask_gain (signed Q2.15)  out_o.valid && out_o.ready
//
// Per item, the 32-step quotient d2/D^2 (skipped when it saturates) and
// the 16-step gain quotient run on the shared divider, and each of n power
// steps (n = clamped filter order) is one pass through the shared multiplier
// plus a register stage. in_i.ready is high only while the sequencer idles.
// A finished result sits in the output register; a new item is accepted
// while it waits, and the next result waits for that register to drain.
// Reset (rst_ni low, asynchronous) loads the config defaults: radius 30,
// order 2, low-pass, 512 x 512. cfg_i.ready is always high.
`include "butterworth_mask_coefficient_defines.svh"

module butterworth_mask_coefficient import bmc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmc_cfg_if.sink   cfg_i,
  bmc_in_if.sink    in_i,
  bmc_out_if.source out_o
);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQR    = 4'd1;  // issue dr*dr
  localparam logic [3:0] S_SQC    = 4'd2;  // issue dc*dc
  localparam logic [3:0] S_SQD    = 4'd3;  // issue D*D
  localparam logic [3:0] S_QCHK   = 4'd4;  // latch D^2
  localparam logic [3:0] S_QSTART = 4'd5;  // saturate or start d2/D^2
  localparam logic [3:0] S_QDIV   = 4'd6;
  localparam logic [3:0] S_POW    = 4'd7;  // issue p*q
  localparam logic [3:0] S_POWW   = 4'd8;  // take p*q >> 16
  localparam logic [3:0] S_HSTART = 4'd9;
  localparam logic [3:0] S_HDIV   = 4'd10;
  localparam logic [3:0] S_FIN    = 4'd11;

  localparam logic [Q_W-1:0]         ONE_Q    = Q_W'(1) << Q_FRAC;
  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC_BITS;

  // config registers
  logic [RAD_W-1:0]  radius_q;
  logic [ORD_W-1:0]  order_cfg_q;
  logic [KIND_W-1:0] kind_q;
  logic [DIM_W-1:0]  rows_q, cols_q;

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  dr_q, dc_q;
  logic [RAD_W-1:0]  rad_q;
  logic [ORD_W-1:0]  order_q, k_q;
  logic [D2_W-1:0]   d2_q;
  logic [DENR_W-1:0] denr_q;
  logic [Q_W-1:0]    q_q, p_q;
  logic [H_W-1:0]    h_q;
  logic signed [GAIN_W-1:0] gain_q, gain_d;
  logic              out_valid_q;

  logic              in_acc, out_acc, out_free, q_sat;
  logic [DIM_W-1:0]  rows_cl, cols_cl;
  logic [IDX_W-1:0]  crow, ccol, dr_d, dc_d;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [DEN_W-1:0]  hden;
  logic [HNUM_W-1:0] hnum;
  logic [GAIN_W-1:0] h_ext;
  div_req_t          div_req;
  logic [DVD_W-1:0]  div_quot;
  logic              div_done;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_acc     = out_o.valid && out_o.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.mask_gain = gain_q;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= RAD_W'(30);
      order_cfg_q <= ORD_W'(2);
      kind_q      <= KIND_LOW;
      rows_q      <= DIM_W'(512);
      cols_q      <= DIM_W'(512);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_RADIUS: radius_q    <= cfg_i.data[RAD_W-1:0];
        CFG_ORDER:  order_cfg_q <= cfg_i.data[ORD_W-1:0];
        CFG_KIND:   kind_q      <= cfg_i.data[KIND_W-1:0];
        CFG_ROWS:   rows_q      <= cfg_i.data[DIM_W-1:0];
        CFG_COLS:   cols_q      <= cfg_i.data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // centre and distances at accept time
  assign rows_cl = (rows_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : rows_q;
  assign cols_cl = (cols_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : cols_q;
  assign crow    = rows_cl[DIM_W-1:1];
  assign ccol    = cols_cl[DIM_W-1:1];
  assign dr_d = (in_i.row_index >= crow) ? in_i.row_index - crow : crow - in_i.row_index;
  assign dc_d = (in_i.col_index >= ccol) ? in_i.col_index - ccol : ccol - in_i.col_index;

  // d2 at or above D^2 * 2^16 means q would not fit in 32 bits
  assign q_sat = ({{(DENR_W + Q_FRAC - D2_W){1'b0}}, d2_q} >= {denr_q, {Q_FRAC{1'b0}}});

  // gain quotient: round-half-up of 2^(F+16) / (2^16 + p)
  assign hden = {1'b0, p_q} + DEN_W'(ONE_Q);
  assign hnum = (HNUM_W'(1) << (GAIN_FRAC_BITS + Q_FRAC)) + HNUM_W'(hden >> 1);

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQR: begin
        mul_a = MUL_W'(dr_q);
        mul_b = MUL_W'(dr_q);
      end
      S_SQC: begin
        mul_a = MUL_W'(dc_q);
        mul_b = MUL_W'(dc_q);
      end
      S_SQD: begin
        mul_a = MUL_W'(rad_q);
        mul_b = MUL_W'(rad_q);
      end
      S_POW: begin
        mul_a = p_q;
        mul_b = q_q;
      end
      default: ;
    endcase
  end

  // divider requests
  always_comb begin
    div_req = '0;
    if (state_q == S_QSTART && !q_sat) begin
      div_req.start = 1'b1;
      div_req.rem   = DEN_W'(d2_q >> Q_FRAC);
      div_req.dvd   = {d2_q[Q_FRAC-1:0], {(DVD_W - Q_FRAC){1'b0}}};
      div_req.den   = DEN_W'(denr_q);
      div_req.steps = Q_STEPS;
    end else if (state_q == S_HSTART) begin
      div_req.start = 1'b1;
      div_req.rem   = DEN_W'(hnum >> H_W);
      div_req.dvd   = {hnum[H_W-1:0], {(DVD_W - H_W){1'b0}}};
      div_req.den   = hden;
      div_req.steps = H_STEPS;
    end
  end

  bmc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  bmc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .quot_o (div_quot),
    .done_o (div_done)
  );

  // output coefficient by filter kind
  assign h_ext = GAIN_W'(h_q);
  always_comb begin
    case (kind_q)
      KIND_LOW:  gain_d = h_ext;
      KIND_HIGH: gain_d = GAIN_ONE - h_ext;
      KIND_DIFF: gain_d = GAIN_ONE - (h_ext << 1);
      default:   gain_d = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SQR;
      S_SQR:    state_d = S_SQC;
      S_SQC:    state_d = S_SQD;
      S_SQD:    state_d = S_QCHK;
      S_QCHK:   state_d = S_QSTART;
      S_QSTART: state_d = q_sat ? S_POW : S_QDIV;
      S_QDIV:   if (div_done) state_d = S_POW;
      S_POW:    state_d = (k_q == order_q) ? S_HSTART : S_POWW;
      S_POWW:   state_d = S_POW;
      S_HSTART: state_d = S_HDIV;
      S_HDIV:   if (div_done) state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dr_q    <= dr_d;
      dc_q    <= dc_d;
      rad_q   <= (radius_q == '0) ? RAD_W'(1) : radius_q;
      order_q <= (order_cfg_q > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) : order_cfg_q;
    end
    case (state_q)
      S_SQC:  d2_q   <= D2_W'(prod[2*IDX_W-1:0]);
      S_SQD:  d2_q   <= d2_q + D2_W'(prod[2*IDX_W-1:0]);
      S_QCHK: denr_q <= prod[DENR_W-1:0];
      S_QSTART: begin
        if (q_sat) begin
          q_q <= '1;
          p_q <= ONE_Q;
          k_q <= '0;
        end
      end
      S_QDIV: begin
        if (div_done) begin
          q_q <= div_quot[Q_W-1:0];
          p_q <= ONE_Q;
          k_q <= '0;
        end
      end
      S_POWW: begin
        // truncate to 16 fraction bits, saturate at 2^32 - 1
        p_q <= (prod[PROD_W-1:Q_W+Q_FRAC] != '0) ? '1 : prod[Q_W+Q_FRAC-1:Q_FRAC];
        k_q <= k_q + ORD_W'(1);
      end
      S_HDIV: if (div_done) h_q <= div_quot[H_W-1:0];
      S_FIN:  if (out_free) gain_q <= gain_d;
      default: ;
    endcase
  end

  `BMC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "ready high right after accept")
  `BMC_ASSERT_IMP(a_gain_range, clk_i, rst_ni, out_o.valid, (out_o.mask_gain <= GAIN_ONE) && (out_o.mask_gain >= -GAIN_ONE), "coefficient out of range")
  `BMC_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, div_done, (state_q == S_QDIV) || (state_q == S_HDIV), "divider done outside divide state")
  `BMC_ASSERT_IMP(a_pow_count, clk_i, rst_ni, state_q == S_POWW, k_q < order_q, "power step past order")

endmodule
